/* design/leac_pkg.sv */
// Shared constants and helpers for the lane edge anomaly classifier.
// Holds the anomaly and element codes, register map and counter helper.
// No dependencies.
`default_nettype none

package leac_pkg;

    localparam int CNT_BITS = 8;
    localparam int RUN_LIMIT_BITS = 8;
    localparam int JUMP_DIST_BITS = 10;
    localparam int JUMP_CNT_BITS = 8;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    localparam logic [RUN_LIMIT_BITS-1:0] RUN_LIMIT_RESET = 8'd5;
    localparam logic [JUMP_DIST_BITS-1:0] JUMP_DIST_RESET = 10'd10;
    localparam logic [JUMP_CNT_BITS-1:0] JUMP_CNT_RESET = 8'd3;

    typedef logic [1:0] anomaly_t;
    localparam anomaly_t ANOM_NONE = 2'd0;
    localparam anomaly_t ANOM_DISAPPEAR = 2'd1;
    localparam anomaly_t ANOM_JUMP = 2'd2;

    typedef logic [1:0] element_t;
    localparam element_t ELEM_NONE = 2'd0;
    localparam element_t ELEM_LEFT_TURN = 2'd1;
    localparam element_t ELEM_RIGHT_TURN = 2'd2;
    localparam element_t ELEM_CROSS = 2'd3;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_RUN_LIMIT = 2'd0;
    localparam reg_idx_t REG_JUMP_DIST = 2'd1;
    localparam reg_idx_t REG_JUMP_CNT = 2'd2;

    // Saturating increment for the run and jump counters
    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] x);
        return (x == {CNT_BITS{1'b1}}) ? x : x + CNT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

/* design/lane_edge_anomaly_classifier_unit.sv */
// Lane edge anomaly classifier: per-side edge trackers and frame classification.
// Depends on leac_pkg for codes, register map and the saturating counter helper.
//
// A top row passes the input register, then the result register, to its m_ beat.
// Throughput: one row per cycle; the input register takes a new beat each cycle
// unless it holds a top row while the result register is full and not drained.
// Reset (aresetn low, synchronous): trackers cleared, limits to 5 / 10 / 3.
`default_nettype none

module lane_edge_anomaly_classifier_unit
    import leac_pkg::*;
#(
    parameter int COLUMN_BITS = 11,
    parameter int ROW_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]      paddr,
    input  wire logic [APB_DATA_BITS-1:0]      pwdata,
    output      logic [APB_DATA_BITS-1:0]      prdata,
    output      logic                          pready,
    // row input
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic signed [COLUMN_BITS-1:0] s_left_edge,
    input  wire logic signed [COLUMN_BITS-1:0] s_right_edge,
    input  wire logic [ROW_BITS-1:0]           s_row_index,
    input  wire logic                          s_frame_end,
    // frame result
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic [1:0]                    m_element_kind,
    output      logic [ROW_BITS-1:0]           m_element_row,
    output      logic [1:0]                    m_left_anomaly_kind,
    output      logic [1:0]                    m_right_anomaly_kind,
    output      logic                          m_roundabout_check_needed
);

    localparam int DW = (COLUMN_BITS + 1 > JUMP_DIST_BITS) ? COLUMN_BITS + 1 : JUMP_DIST_BITS;

    // configuration
    logic [RUN_LIMIT_BITS-1:0] run_limit_reg;
    logic [JUMP_DIST_BITS-1:0] jump_dist_reg;
    logic [JUMP_CNT_BITS-1:0]  jump_cnt_limit_reg;
    reg_idx_t                  cfg_idx;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_limit_reg      <= RUN_LIMIT_RESET;
            jump_dist_reg      <= JUMP_DIST_RESET;
            jump_cnt_limit_reg <= JUMP_CNT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_RUN_LIMIT: run_limit_reg <= pwdata[RUN_LIMIT_BITS-1:0];
                REG_JUMP_DIST: jump_dist_reg <= pwdata[JUMP_DIST_BITS-1:0];
                REG_JUMP_CNT:  jump_cnt_limit_reg <= pwdata[JUMP_CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_RUN_LIMIT: prdata = APB_DATA_BITS'(run_limit_reg);
            REG_JUMP_DIST: prdata = APB_DATA_BITS'(jump_dist_reg);
            REG_JUMP_CNT:  prdata = APB_DATA_BITS'(jump_cnt_limit_reg);
            default:       prdata = '0;
        endcase
    end

    // input register
    logic                          in_valid_reg;
    logic signed [COLUMN_BITS-1:0] left_reg;
    logic signed [COLUMN_BITS-1:0] right_reg;
    logic [ROW_BITS-1:0]           row_reg;
    logic                          frame_end_reg;
    logic                          s_beat;
    logic                          advance;
    logic                          m_valid_reg;

    // an item without frame_end never waits on the result side
    assign advance = in_valid_reg && (!frame_end_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_beat  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_beat) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            left_reg      <= s_left_edge;
            right_reg     <= s_right_edge;
            row_reg       <= s_row_index;
            frame_end_reg <= s_frame_end;
        end
    end

    // per-side tracker state, index 0 left, 1 right
    logic [CNT_BITS-1:0]           run_reg [2];
    logic                          stable_valid_reg [2];
    logic signed [COLUMN_BITS-1:0] stable_col_reg [2];
    logic [CNT_BITS-1:0]           jcnt_reg [2];
    anomaly_t                      kind_reg [2];
    logic [ROW_BITS-1:0]           arow_reg [2];

    logic [CNT_BITS-1:0]           run_upd [2];
    logic                          stable_valid_upd [2];
    logic signed [COLUMN_BITS-1:0] stable_col_upd [2];
    logic [CNT_BITS-1:0]           jcnt_upd [2];
    anomaly_t                      kind_upd [2];
    logic [ROW_BITS-1:0]           arow_upd [2];

    logic signed [COLUMN_BITS-1:0] col [2];
    logic signed [DW:0]            diff [2];
    logic [DW:0]                   abs_diff [2];

    assign col[0] = left_reg;
    assign col[1] = right_reg;

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            diff[s] = (DW+1)'(col[s]) - (DW+1)'(stable_col_reg[s]);
            abs_diff[s] = diff[s][DW] ? $unsigned(-diff[s]) : $unsigned(diff[s]);
        end
    end

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            run_upd[s]          = run_reg[s];
            stable_valid_upd[s] = stable_valid_reg[s];
            stable_col_upd[s]   = stable_col_reg[s];
            jcnt_upd[s]         = jcnt_reg[s];
            kind_upd[s]         = kind_reg[s];
            arow_upd[s]         = arow_reg[s];
            // a latched side ignores the rest of the frame
            if (kind_reg[s] == ANOM_NONE) begin
                if (col[s][COLUMN_BITS-1]) begin
                    run_upd[s] = sat_inc(run_reg[s]);
                    if (run_upd[s] >= run_limit_reg) begin
                        kind_upd[s] = ANOM_DISAPPEAR;
                        arow_upd[s] = row_reg;
                    end
                end else begin
                    run_upd[s] = '0;
                    if (stable_valid_reg[s] && (abs_diff[s] > (DW+1)'(jump_dist_reg))) begin
                        jcnt_upd[s] = sat_inc(jcnt_reg[s]);
                        if (jcnt_upd[s] >= jump_cnt_limit_reg) begin
                            kind_upd[s] = ANOM_JUMP;
                            arow_upd[s] = row_reg;
                        end
                    end else begin
                        stable_valid_upd[s] = 1'b1;
                        stable_col_upd[s]   = col[s];
                        jcnt_upd[s]         = '0;
                    end
                end
            end
        end
    end

    // state is cleared once the top row of a frame has gone through
    always_ff @(posedge aclk) begin
        for (int s = 0; s < 2; s++) begin
            if (!aresetn || (advance && frame_end_reg)) begin
                run_reg[s]          <= '0;
                stable_valid_reg[s] <= 1'b0;
                stable_col_reg[s]   <= '0;
                jcnt_reg[s]         <= '0;
                kind_reg[s]         <= ANOM_NONE;
                arow_reg[s]         <= '0;
            end else if (advance) begin
                run_reg[s]          <= run_upd[s];
                stable_valid_reg[s] <= stable_valid_upd[s];
                stable_col_reg[s]   <= stable_col_upd[s];
                jcnt_reg[s]         <= jcnt_upd[s];
                kind_reg[s]         <= kind_upd[s];
                arow_reg[s]         <= arow_upd[s];
            end
        end
    end

    // frame classification
    element_t             elem_next;
    logic [ROW_BITS-1:0]  erow_next;
    logic [ROW_BITS:0]    row_sum;

    assign row_sum = {1'b0, arow_upd[0]} + {1'b0, arow_upd[1]};

    always_comb begin
        priority if (kind_upd[0] == ANOM_JUMP && kind_upd[1] == ANOM_JUMP) begin
            elem_next = ELEM_CROSS;
            erow_next = row_sum[ROW_BITS:1];
        end else if (kind_upd[0] == ANOM_JUMP && kind_upd[1] == ANOM_DISAPPEAR) begin
            elem_next = ELEM_LEFT_TURN;
            erow_next = arow_upd[0];
        end else if (kind_upd[0] == ANOM_DISAPPEAR && kind_upd[1] == ANOM_JUMP) begin
            elem_next = ELEM_RIGHT_TURN;
            erow_next = arow_upd[1];
        end else begin
            elem_next = ELEM_NONE;
            erow_next = '0;
        end
    end

    // result register
    element_t            elem_reg;
    logic [ROW_BITS-1:0] erow_reg;
    anomaly_t            left_kind_reg;
    anomaly_t            right_kind_reg;
    logic                load_result;

    assign load_result = advance && frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            elem_reg       <= elem_next;
            erow_reg       <= erow_next;
            left_kind_reg  <= kind_upd[0];
            right_kind_reg <= kind_upd[1];
        end
    end

    assign m_valid                   = m_valid_reg;
    assign m_element_kind            = elem_reg;
    assign m_element_row             = erow_reg;
    assign m_left_anomaly_kind       = left_kind_reg;
    assign m_right_anomaly_kind      = right_kind_reg;
    assign m_roundabout_check_needed = (elem_reg == ELEM_NONE);

endmodule

`default_nettype wire

/* test/tb_lane_edge_anomaly_classifier_unit.sv */
// Self-checking testbench for lane_edge_anomaly_classifier_unit: directed rows, then random frames.
// Uses its own tracker predictor and APB register writes, with idling and backpressure on both sides.
// Depends on leac_pkg and the top-level RTL only.
`default_nettype none

module tb_lane_edge_anomaly_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import leac_pkg::*;

    localparam int COL_W = 11;
    localparam int ROW_W = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ROWS = 110;
    localparam int END_WAIT = 20000;
    localparam int TIMEOUT_NS = 2_000_000;
    localparam int SCRIPT_LEN = 21;
    localparam int ZERO_LIMIT_AT = 18;

    typedef struct packed {
        element_t         elem_kind;
        logic [ROW_W-1:0] elem_row;
        anomaly_t         left_anom;
        anomaly_t         right_anom;
        logic             roundabout;
    } frame_result_t;

    typedef struct packed {
        logic signed [COL_W-1:0] l_edge;
        logic signed [COL_W-1:0] r_edge;
        logic [ROW_W-1:0]        row;
        logic                    last;
        logic                    typed;
        element_t                w_kind;
        logic [ROW_W-1:0]        w_row;
        anomaly_t                w_left;
        anomaly_t                w_right;
        logic                    w_rb;
    } lane_row_t;

    typedef enum int {MODE_STEADY, MODE_FADE, MODE_SHIFT, MODE_NOISE} lane_mode_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [COL_W-1:0]  s_left_edge = '0;
    logic signed [COL_W-1:0]  s_right_edge = '0;
    logic [ROW_W-1:0]         s_row_index = '0;
    logic                     s_frame_end = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [1:0]               m_element_kind;
    logic [ROW_W-1:0]         m_element_row;
    logic [1:0]               m_left_anomaly_kind;
    logic [1:0]               m_right_anomaly_kind;
    logic                     m_roundabout_check_needed;

    lane_edge_anomaly_classifier_unit #(
        .COLUMN_BITS(COL_W),
        .ROW_BITS(ROW_W)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_left_edge(s_left_edge),
        .s_right_edge(s_right_edge),
        .s_row_index(s_row_index),
        .s_frame_end(s_frame_end),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_element_kind(m_element_kind),
        .m_element_row(m_element_row),
        .m_left_anomaly_kind(m_left_anomaly_kind),
        .m_right_anomaly_kind(m_right_anomaly_kind),
        .m_roundabout_check_needed(m_roundabout_check_needed)
    );

    // Tracker model, index 0 left, 1 right
    logic [RUN_LIMIT_BITS-1:0] cfg_run_limit;
    logic [JUMP_DIST_BITS-1:0] cfg_jump_dist;
    logic [JUMP_CNT_BITS-1:0]  cfg_jump_cnt;
    logic [7:0]                trk_missing [2];
    logic                      trk_stable_ok [2];
    logic signed [COL_W-1:0]   trk_col [2];
    logic [7:0]                trk_jumps [2];
    anomaly_t                  trk_anom [2];
    logic [ROW_W-1:0]          trk_anom_row [2];

    frame_result_t frame_results_due [$];
    int            fail_count = 0;
    int            rows_sent = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_start = 1'b0;
    int            hold_left = 0;

    // Directed rows; typed expectations only where the answer is obvious
    lane_row_t lane_script [SCRIPT_LEN] = '{
        '{11'sd0, 11'sd0, 8'd0, 1'b1, 1'b1, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b1},
        // left fades out, right jumps: right turn
        '{-11'sd1, 11'sd100, 8'd0, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{-11'sd1, 11'sd200, 8'd1, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{-11'sd1, 11'sd300, 8'd2, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{-11'sd1, 11'sd400, 8'd3, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{-11'sd1, 11'sd400, 8'd4, 1'b1, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        // left jumps to the far edge, right missing with assorted negatives: left turn
        '{11'sd0, -11'sd1024, 8'd10, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{11'sd1023, -11'sd5, 8'd11, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{11'sd1023, -11'sd2, 8'd12, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{11'sd1023, -11'sd1024, 8'd13, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{11'sd1023, -11'sd3, 8'd14, 1'b1, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        // both jump at the top rows; a missing right row keeps its jump count: cross
        '{11'sd500, 11'sd500, 8'd249, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{11'sd0, 11'sd1023, 8'd250, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{11'sd0, 11'sd505, 8'd251, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{11'sd0, 11'sd1023, 8'd252, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{-11'sd1, -11'sd1, 8'd253, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{-11'sd1, 11'sd1023, 8'd254, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{-11'sd1, 11'sd1023, 8'd255, 1'b1, 1'b1, ELEM_CROSS, 8'd253, ANOM_JUMP, ANOM_JUMP, 1'b0},
        // all limits zero from here
        '{11'sd5, -11'sd1, 8'd7, 1'b0, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{11'sd6, 11'sd8, 8'd9, 1'b1, 1'b0, ELEM_NONE, 8'd0, ANOM_NONE, ANOM_NONE, 1'b0},
        '{-11'sd1, 11'sd3, 8'd0, 1'b1, 1'b1, ELEM_NONE, 8'd0, ANOM_DISAPPEAR, ANOM_NONE, 1'b1}
    };

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("lane_edge_anomaly_classifier_unit test failed");
        $finish;
    end

    function automatic void clear_trackers();
        for (int s = 0; s < 2; s++) begin
            trk_missing[s] = '0;
            trk_stable_ok[s] = 1'b0;
            trk_col[s] = '0;
            trk_jumps[s] = '0;
            trk_anom[s] = ANOM_NONE;
            trk_anom_row[s] = '0;
        end
    endfunction

    function automatic void track_edge(input int s, input logic signed [COL_W-1:0] col,
                                       input logic [ROW_W-1:0] row);
        int d;
        if (trk_anom[s] != ANOM_NONE)
            return;
        if (col < 0) begin
            if (trk_missing[s] != 8'hFF)
                trk_missing[s] += 8'd1;
            if (trk_missing[s] >= cfg_run_limit) begin
                trk_anom[s] = ANOM_DISAPPEAR;
                trk_anom_row[s] = row;
            end
            return;
        end
        trk_missing[s] = '0;
        if (trk_stable_ok[s]) begin
            d = int'(col) - int'(trk_col[s]);
            if (d < 0)
                d = -d;
            if (d > int'(cfg_jump_dist)) begin
                // jump rows leave the stable column where it was
                if (trk_jumps[s] != 8'hFF)
                    trk_jumps[s] += 8'd1;
                if (trk_jumps[s] >= cfg_jump_cnt) begin
                    trk_anom[s] = ANOM_JUMP;
                    trk_anom_row[s] = row;
                end
                return;
            end
        end
        trk_stable_ok[s] = 1'b1;
        trk_col[s] = col;
        trk_jumps[s] = '0;
    endfunction

    function automatic frame_result_t close_frame();
        frame_result_t res;
        res = '0;
        if (trk_anom[0] == ANOM_JUMP && trk_anom[1] == ANOM_JUMP) begin
            res.elem_kind = ELEM_CROSS;
            res.elem_row = ROW_W'(({1'b0, trk_anom_row[0]} + {1'b0, trk_anom_row[1]}) >> 1);
        end else if (trk_anom[0] == ANOM_JUMP && trk_anom[1] == ANOM_DISAPPEAR) begin
            res.elem_kind = ELEM_LEFT_TURN;
            res.elem_row = trk_anom_row[0];
        end else if (trk_anom[0] == ANOM_DISAPPEAR && trk_anom[1] == ANOM_JUMP) begin
            res.elem_kind = ELEM_RIGHT_TURN;
            res.elem_row = trk_anom_row[1];
        end
        res.left_anom = trk_anom[0];
        res.right_anom = trk_anom[1];
        res.roundabout = (res.elem_kind == ELEM_NONE);
        clear_trackers();
        return res;
    endfunction

    function automatic logic signed [COL_W-1:0] pick_col(input lane_mode_t mode, input int base,
                                                         input bit late);
        int c;
        int span;
        int miss;
        span = int'(cfg_jump_dist);
        miss = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(1, 1024)) : -1;
        c = base + int'($urandom_range(0, span / 2));
        case (mode)
            MODE_FADE: begin
                if (late)
                    c = miss;
            end
            MODE_SHIFT: begin
                if (late) begin
                    if ($urandom_range(0, 7) == 0) begin
                        c = miss;
                    end else begin
                        c = base + span + 1 + int'($urandom_range(0, 200));
                        if (c > 1023)
                            c = base - span - 1 - int'($urandom_range(0, 200));
                        if (c < 0)
                            c = 1023;
                    end
                end
            end
            MODE_NOISE: begin
                c = ($urandom_range(0, 3) == 0) ? miss : int'($urandom_range(0, 1023));
            end
            default: ;
        endcase
        if (c > 1023)
            c = 1023;
        return COL_W'(c);
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_limits(input int run, input int dist_limit, input int cnt);
        apb_write(REG_RUN_LIMIT, APB_DATA_BITS'(run));
        apb_write(REG_JUMP_DIST, APB_DATA_BITS'(dist_limit));
        apb_write(REG_JUMP_CNT, APB_DATA_BITS'(cnt));
        cfg_run_limit = RUN_LIMIT_BITS'(run);
        cfg_jump_dist = JUMP_DIST_BITS'(dist_limit);
        cfg_jump_cnt = JUMP_CNT_BITS'(cnt);
    endtask

    // Stop sending and let every outstanding frame result drain
    task automatic settle_block();
        s_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_row(input logic signed [COL_W-1:0] l_col,
                            input logic signed [COL_W-1:0] r_col,
                            input logic [ROW_W-1:0] row, input bit last,
                            input bit typed, input frame_result_t typed_want);
        frame_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_left_edge <= l_col;
        s_right_edge <= r_col;
        s_row_index <= row;
        s_frame_end <= last;
        do @(posedge aclk); while (!s_ready);
        track_edge(0, l_col, row);
        track_edge(1, r_col, row);
        if (last) begin
            predicted = close_frame();
            frame_results_due.push_back(typed ? typed_want : predicted);
        end
        rows_sent++;
    endtask

    // One frame of rows; saturate forces a long fade on the left and endless jumps on the right
    task automatic send_frame(input int len, input bit saturate);
        lane_mode_t mode [2];
        int base [2];
        int shift_at [2];
        int row0;
        logic signed [COL_W-1:0] col [2];
        row0 = $urandom_range(0, 255);
        for (int s = 0; s < 2; s++) begin
            mode[s] = lane_mode_t'($urandom_range(0, 3));
            base[s] = $urandom_range(0, 1023);
            shift_at[s] = $urandom_range(0, len - 1);
        end
        if (saturate) begin
            mode[0] = MODE_FADE;
            shift_at[0] = 0;
            mode[1] = MODE_SHIFT;
            base[1] = 0;
            shift_at[1] = 1;
        end
        for (int i = 0; i < len; i++) begin
            for (int s = 0; s < 2; s++)
                col[s] = pick_col(mode[s], base[s], i >= shift_at[s]);
            send_row(col[0], col[1], ROW_W'(row0 + i), i == len - 1, 1'b0, '0);
        end
    endtask

    // Result side: check each beat, then pick m_ready for the next cycle
    initial begin
        frame_result_t got;
        frame_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_element_kind, m_element_row, m_left_anomaly_kind,
                       m_right_anomaly_kind, m_roundabout_check_needed};
                if (frame_results_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = frame_results_due.pop_front();
                    check_field("element_kind", want.elem_kind, got.elem_kind);
                    check_field("element_row", want.elem_row, got.elem_row);
                    check_field("left_anomaly_kind", want.left_anom, got.left_anom);
                    check_field("right_anomaly_kind", want.right_anom, got.right_anom);
                    check_field("roundabout_check_needed", want.roundabout, got.roundabout);
                end
            end
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        frame_result_t typed_want;
        int budget;
        int len;
        int waited;
        cfg_run_limit = RUN_LIMIT_RESET;
        cfg_jump_dist = JUMP_DIST_RESET;
        cfg_jump_cnt = JUMP_CNT_RESET;
        clear_trackers();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (i == ZERO_LIMIT_AT) begin
                settle_block();
                set_limits(0, 0, 0);
            end
            typed_want = {lane_script[i].w_kind, lane_script[i].w_row, lane_script[i].w_left,
                          lane_script[i].w_right, lane_script[i].w_rb};
            send_row(lane_script[i].l_edge, lane_script[i].r_edge, lane_script[i].row,
                     lane_script[i].last, lane_script[i].typed, typed_want);
        end

        // Long receiver hold-off while single-row frames keep coming, so the input backs up
        settle_block();
        hold_start = 1'b1;
        repeat (40) send_frame(1, 1'b0);
        settle_block();

        for (int p = 0; p < 8; p++) begin
            settle_block();
            case (p)
                0: set_limits(1, 0, 1);
                1: set_limits(255, 1023, 255);
                2: set_limits(255, 0, 255);
                default: begin
                    set_limits(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8),
                               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 40),
                               ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5));
                end
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            budget = rows_sent + PHASE_ROWS;
            if (p == 2)
                send_frame(300, 1'b1);
            while (rows_sent < budget) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
                send_frame(len, 1'b0);
            end
        end

        s_valid <= 1'b0;
        waited = 0;
        while (frame_results_due.size() != 0 && waited < END_WAIT) begin
            @(posedge aclk);
            waited++;
        end
        if (frame_results_due.size() != 0) begin
            $display("%0t: %0d frame results never arrived, expected 0 outstanding, got %0d",
                     $time, frame_results_due.size(), frame_results_due.size());
            fail_count += frame_results_due.size();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("lane_edge_anomaly_classifier_unit test passed");
        else
            $display("lane_edge_anomaly_classifier_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
